// File: hw/rtl/asi_pkg.sv
`timescale 1ns / 1ps

package asi_pkg;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ARM    = 2'd1,
        OP_DISARM = 2'd2,
        OP_ESTOP  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_BOOT     = 3'd0,
        ST_DISARMED = 3'd1,
        ST_PREARM   = 3'd2,
        ST_ARMED    = 3'd3,
        ST_FAILSAFE = 3'd4,
        ST_ERROR    = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_DISARM = 2'd1,
        CMD_ARM    = 2'd2,
        CMD_ESTOP  = 2'd3
    } t_cmd;

    localparam logic [3:0] FAIL_NONE          = 4'd0;
    localparam logic [3:0] FAIL_EST_INIT      = 4'd1;
    localparam logic [3:0] FAIL_EST_STALE     = 4'd2;
    localparam logic [3:0] FAIL_SENSOR        = 4'd3;
    localparam logic [3:0] FAIL_MOTOR_NREADY  = 4'd4;
    localparam logic [3:0] FAIL_MOTOR_ARMED   = 4'd5;
    localparam logic [3:0] FAIL_BOOT_SENSOR   = 4'd6;
    localparam logic [3:0] FAIL_DISARM_SENSOR = 4'd7;
    localparam logic [3:0] FAIL_MOTOR_DROP    = 4'd8;
    localparam logic [3:0] FAIL_FS_SENSOR     = 4'd9;
    localparam logic [3:0] FAIL_ESTOP         = 4'd10;
    localparam logic [3:0] FAIL_BAD_STATE     = 4'd11;

    localparam logic       CFG_PREARM = 1'b0;
    localparam logic       CFG_STALE  = 1'b1;

    localparam logic [15:0] PREARM_TIMEOUT_RST = 16'd5000;
    localparam logic [15:0] STALE_TIMEOUT_RST  = 16'd200;

    typedef struct packed {
        logic [15:0] prearm_timeout_ms;
        logic [15:0] stale_timeout_ms;
    } t_cfg;

    typedef struct packed {
        t_op         opcode;
        logic [31:0] now_ms;
        logic        estimator_ready;
        logic [31:0] estimator_time_ms;
        logic        sensor_init_fault;
        logic        motor_ready;
        logic        motor_is_armed;
    } t_item;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] entry_time_ms;
        logic        arm_pending;
        logic        disarm_pending;
        logic [3:0]  last_failure;
    } t_state;

    typedef struct packed {
        t_mode       safety_state;
        logic        accepted;
        t_cmd        motor_command;
        logic        rate_reset;
        logic [3:0]  failure_code;
        logic [31:0] entry_time_ms;
        logic        can_arm;
    } t_result;

endpackage

// File: hw/rtl/asi_cfg.sv
`timescale 1ns / 1ps

module asi_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_addr,
    input  logic [15:0]   i_cfg_wdata,
    output asi_pkg::t_cfg o_cfg
);

    asi_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prearm_timeout_ms <= asi_pkg::PREARM_TIMEOUT_RST;
            r_cfg.stale_timeout_ms  <= asi_pkg::STALE_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                asi_pkg::CFG_PREARM: r_cfg.prearm_timeout_ms <= i_cfg_wdata;
                asi_pkg::CFG_STALE:  r_cfg.stale_timeout_ms  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/asi_step.sv
`timescale 1ns / 1ps

module asi_step (
    input  asi_pkg::t_cfg    i_cfg,
    input  asi_pkg::t_state  i_state,
    input  asi_pkg::t_item   i_item,
    output asi_pkg::t_state  o_state,
    output asi_pkg::t_result o_result
);

    asi_pkg::t_state n_state;
    asi_pkg::t_mode  go_mode;
    asi_pkg::t_cmd   cmd;
    logic            go;
    logic [3:0]      go_code;
    logic [3:0]      est_code;
    logic [3:0]      pre_code;
    logic            acc;
    logic            pid;
    logic [31:0]     est_age;
    logic [31:0]     state_age;

    assign est_age   = i_item.now_ms - i_item.estimator_time_ms;
    assign state_age = i_item.now_ms - i_state.entry_time_ms;

    always_comb begin
        if (!i_item.estimator_ready) begin
            est_code = asi_pkg::FAIL_EST_INIT;
        end else if (est_age > {16'd0, i_cfg.stale_timeout_ms}) begin
            est_code = asi_pkg::FAIL_EST_STALE;
        end else begin
            est_code = asi_pkg::FAIL_NONE;
        end

        if (!i_item.motor_ready) begin
            pre_code = asi_pkg::FAIL_MOTOR_NREADY;
        end else if (est_code != asi_pkg::FAIL_NONE) begin
            pre_code = est_code;
        end else if (i_item.sensor_init_fault) begin
            pre_code = asi_pkg::FAIL_SENSOR;
        end else if (i_item.motor_is_armed) begin
            pre_code = asi_pkg::FAIL_MOTOR_ARMED;
        end else begin
            pre_code = asi_pkg::FAIL_NONE;
        end
    end

    always_comb begin
        n_state = i_state;
        acc     = 1'b1;
        cmd     = asi_pkg::CMD_NONE;
        pid     = 1'b0;
        go      = 1'b0;
        go_mode = asi_pkg::ST_BOOT;
        go_code = asi_pkg::FAIL_NONE;

        case (i_item.opcode)
            asi_pkg::OP_TICK: begin
                case (i_state.mode)
                    asi_pkg::ST_BOOT: begin
                        go = 1'b1;
                        if (i_item.sensor_init_fault) begin
                            go_mode = asi_pkg::ST_ERROR;
                            go_code = asi_pkg::FAIL_BOOT_SENSOR;
                        end else begin
                            go_mode = asi_pkg::ST_DISARMED;
                        end
                    end
                    asi_pkg::ST_DISARMED: begin
                        if (i_state.arm_pending) begin
                            go      = 1'b1;
                            go_mode = asi_pkg::ST_PREARM;
                        end else if (i_item.sensor_init_fault) begin
                            go      = 1'b1;
                            go_mode = asi_pkg::ST_ERROR;
                            go_code = asi_pkg::FAIL_DISARM_SENSOR;
                        end else if (i_item.motor_is_armed) begin
                            cmd = asi_pkg::CMD_DISARM;
                        end
                    end
                    asi_pkg::ST_PREARM: begin
                        go = 1'b1;
                        if (i_state.disarm_pending) begin
                            go_mode = asi_pkg::ST_DISARMED;
                        end else if (state_age > {16'd0, i_cfg.prearm_timeout_ms}) begin
                            go_mode = asi_pkg::ST_DISARMED;
                        end else if (pre_code == asi_pkg::FAIL_NONE) begin
                            go_mode = asi_pkg::ST_ARMED;
                        end else begin
                            n_state.last_failure = pre_code;
                            go_mode = asi_pkg::ST_DISARMED;
                        end
                    end
                    asi_pkg::ST_ARMED: begin
                        if (i_state.disarm_pending) begin
                            go      = 1'b1;
                            go_mode = asi_pkg::ST_DISARMED;
                        end else if (est_code != asi_pkg::FAIL_NONE) begin
                            go      = 1'b1;
                            go_mode = asi_pkg::ST_FAILSAFE;
                            go_code = est_code;
                        end else if (i_item.sensor_init_fault) begin
                            go      = 1'b1;
                            go_mode = asi_pkg::ST_FAILSAFE;
                            go_code = asi_pkg::FAIL_SENSOR;
                        end else if (!i_item.motor_is_armed) begin
                            go      = 1'b1;
                            go_mode = asi_pkg::ST_FAILSAFE;
                            go_code = asi_pkg::FAIL_MOTOR_DROP;
                        end
                    end
                    asi_pkg::ST_FAILSAFE: begin
                        if (i_item.motor_is_armed) begin
                            cmd = asi_pkg::CMD_ESTOP;
                        end
                        if (i_state.disarm_pending) begin
                            go      = 1'b1;
                            go_mode = asi_pkg::ST_DISARMED;
                        end else if (i_item.sensor_init_fault) begin
                            go      = 1'b1;
                            go_mode = asi_pkg::ST_ERROR;
                            go_code = asi_pkg::FAIL_FS_SENSOR;
                        end
                    end
                    asi_pkg::ST_ERROR: begin
                        if (i_item.motor_is_armed) begin
                            cmd = asi_pkg::CMD_ESTOP;
                        end
                    end
                    default: begin
                        go      = 1'b1;
                        go_mode = asi_pkg::ST_ERROR;
                        go_code = asi_pkg::FAIL_BAD_STATE;
                    end
                endcase
                n_state.disarm_pending = 1'b0;
            end
            asi_pkg::OP_ARM: begin
                if (i_state.mode == asi_pkg::ST_DISARMED) begin
                    n_state.arm_pending = 1'b1;
                end else begin
                    acc = 1'b0;
                end
            end
            asi_pkg::OP_DISARM: begin
                if (i_state.mode == asi_pkg::ST_ERROR) begin
                    acc = 1'b0;
                end else begin
                    n_state.disarm_pending = 1'b1;
                end
            end
            default: begin
                go      = 1'b1;
                go_mode = asi_pkg::ST_FAILSAFE;
                go_code = asi_pkg::FAIL_ESTOP;
            end
        endcase

        // state entry actions
        if (go) begin
            n_state.mode          = go_mode;
            n_state.entry_time_ms = i_item.now_ms;
            case (go_mode)
                asi_pkg::ST_BOOT,
                asi_pkg::ST_PREARM: begin
                    cmd = asi_pkg::CMD_DISARM;
                end
                asi_pkg::ST_DISARMED: begin
                    cmd = asi_pkg::CMD_DISARM;
                    pid = 1'b1;
                    n_state.arm_pending = 1'b0;
                end
                asi_pkg::ST_ARMED: begin
                    cmd = asi_pkg::CMD_ARM;
                    pid = 1'b1;
                    n_state.arm_pending = 1'b0;
                end
                default: begin
                    cmd = asi_pkg::CMD_ESTOP;
                    pid = 1'b1;
                    n_state.last_failure = go_code;
                end
            endcase
        end
    end

    assign o_state = n_state;

    assign o_result.safety_state  = n_state.mode;
    assign o_result.accepted      = acc;
    assign o_result.motor_command = cmd;
    assign o_result.rate_reset    = pid;
    assign o_result.failure_code  = n_state.last_failure;
    assign o_result.entry_time_ms = n_state.entry_time_ms;
    assign o_result.can_arm       = (n_state.mode == asi_pkg::ST_DISARMED);

endmodule

// File: hw/rtl/arming_safety_interlock.sv
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_opcode .. i_motor_is_armed
// out       output     o_out_valid / i_out_ready  o_safety_state .. o_can_arm
// cfg       input      i_cfg_we (no wait)         i_cfg_addr, i_cfg_wdata
//
// one event per cycle sustained while the output is not stalled; an event
// that is taken passes through the input register, then the result register,
// before its result is presented
// the state update and the result come from one pass of logic between them
// synchronous active-low reset puts the interlock in boot with no failure
// a stalled output holds its result while the input register still takes one more

module arming_safety_interlock (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_now_ms,
    input  logic        i_estimator_ready,
    input  logic [31:0] i_estimator_time_ms,
    input  logic        i_sensor_init_fault,
    input  logic        i_motor_ready,
    input  logic        i_motor_is_armed,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_safety_state,
    output logic        o_accepted,
    output logic [1:0]  o_motor_command,
    output logic        o_rate_reset,
    output logic [3:0]  o_failure_code,
    output logic [31:0] o_entry_time_ms,
    output logic        o_can_arm
);

    asi_pkg::t_cfg    cfg;
    asi_pkg::t_item   r_in;
    asi_pkg::t_state  r_state;
    asi_pkg::t_state  n_state;
    asi_pkg::t_result n_out;
    asi_pkg::t_result r_out;
    logic             r_in_valid;
    logic             r_out_valid;
    logic             advance;

    asi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    asi_step u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state.mode           <= asi_pkg::ST_BOOT;
            r_state.entry_time_ms  <= 32'd0;
            r_state.arm_pending    <= 1'b0;
            r_state.disarm_pending <= 1'b0;
            r_state.last_failure   <= asi_pkg::FAIL_NONE;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.opcode            <= asi_pkg::t_op'(i_opcode);
            r_in.now_ms            <= i_now_ms;
            r_in.estimator_ready   <= i_estimator_ready;
            r_in.estimator_time_ms <= i_estimator_time_ms;
            r_in.sensor_init_fault <= i_sensor_init_fault;
            r_in.motor_ready       <= i_motor_ready;
            r_in.motor_is_armed    <= i_motor_is_armed;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_safety_state  = r_out.safety_state;
    assign o_accepted      = r_out.accepted;
    assign o_motor_command = r_out.motor_command;
    assign o_rate_reset    = r_out.rate_reset;
    assign o_failure_code  = r_out.failure_code;
    assign o_entry_time_ms = r_out.entry_time_ms;
    assign o_can_arm       = r_out.can_arm;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    typedef enum logic [2:0] {
        UPSET_NONE,
        UPSET_MOTOR_NREADY,
        UPSET_EST_INIT,
        UPSET_EST_STALE,
        UPSET_SENSOR
    } t_upset;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int EVENTS_PER_PHASE = 280;

    logic        i_clk               = 1'b0;
    logic        i_rst_n             = 1'b0;
    logic        i_cfg_we            = 1'b0;
    logic        i_cfg_addr          = asi_pkg::CFG_PREARM;
    logic [15:0] i_cfg_wdata         = '0;
    logic        i_in_valid          = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_opcode            = asi_pkg::OP_TICK;
    logic [31:0] i_now_ms            = '0;
    logic        i_estimator_ready   = 1'b0;
    logic [31:0] i_estimator_time_ms = '0;
    logic        i_sensor_init_fault = 1'b0;
    logic        i_motor_ready       = 1'b0;
    logic        i_motor_is_armed    = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready         = 1'b0;
    logic [2:0]  o_safety_state;
    logic        o_accepted;
    logic [1:0]  o_motor_command;
    logic        o_rate_reset;
    logic [3:0]  o_failure_code;
    logic [31:0] o_entry_time_ms;
    logic        o_can_arm;

    arming_safety_interlock dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // interlock shadow state
    asi_pkg::t_mode mode_q       = asi_pkg::ST_BOOT;
    logic [31:0]    entry_q      = '0;
    logic           arm_q        = 1'b0;
    logic           disarm_q     = 1'b0;
    logic [3:0]     fail_q       = asi_pkg::FAIL_NONE;
    logic [15:0]    prearm_limit = asi_pkg::PREARM_TIMEOUT_RST;
    logic [15:0]    stale_limit  = asi_pkg::STALE_TIMEOUT_RST;
    asi_pkg::t_cmd  cmd_w;
    logic           pid_w;

    asi_pkg::t_result expected_status_q[$];
    int          mismatches      = 0;
    int          results_checked = 0;
    int          events_sent     = 0;
    int          directed_events = 0;
    int          mode_visits[0:5] = '{default: 0};
    int          idle_cycles     = 0;

    // stimulus pacing
    logic [31:0] t_now      = '0;
    int          burst_left = 0;
    bit          steady_tx  = 1'b0;
    bit          rx_stalls  = 1'b1;
    int          rx_hold    = 0;

    function automatic void enter_mode(asi_pkg::t_mode m, logic [31:0] now,
                                       logic [3:0] code);
        mode_q  = m;
        entry_q = now;
        case (m)
            asi_pkg::ST_BOOT, asi_pkg::ST_PREARM: begin
                cmd_w = asi_pkg::CMD_DISARM;
            end
            asi_pkg::ST_DISARMED: begin
                cmd_w = asi_pkg::CMD_DISARM;
                pid_w = 1'b1;
                arm_q = 1'b0;
            end
            asi_pkg::ST_ARMED: begin
                cmd_w = asi_pkg::CMD_ARM;
                pid_w = 1'b1;
                arm_q = 1'b0;
            end
            default: begin
                cmd_w  = asi_pkg::CMD_ESTOP;
                pid_w  = 1'b1;
                fail_q = code;
            end
        endcase
    endfunction

    function automatic logic [3:0] estimator_health(asi_pkg::t_item ev);
        logic [31:0] age;
        age = ev.now_ms - ev.estimator_time_ms;
        if (!ev.estimator_ready) return asi_pkg::FAIL_EST_INIT;
        if (age > {16'd0, stale_limit}) return asi_pkg::FAIL_EST_STALE;
        return asi_pkg::FAIL_NONE;
    endfunction

    function automatic asi_pkg::t_result interlock_step(asi_pkg::t_item ev);
        asi_pkg::t_result r;
        logic [3:0]       code;
        logic [31:0]      dwell;
        cmd_w      = asi_pkg::CMD_NONE;
        pid_w      = 1'b0;
        r.accepted = 1'b1;
        dwell      = ev.now_ms - entry_q;
        case (ev.opcode)
            asi_pkg::OP_TICK: begin
                case (mode_q)
                    asi_pkg::ST_BOOT: begin
                        if (ev.sensor_init_fault)
                            enter_mode(asi_pkg::ST_ERROR, ev.now_ms, asi_pkg::FAIL_BOOT_SENSOR);
                        else
                            enter_mode(asi_pkg::ST_DISARMED, ev.now_ms, asi_pkg::FAIL_NONE);
                    end
                    asi_pkg::ST_DISARMED: begin
                        if (arm_q)
                            enter_mode(asi_pkg::ST_PREARM, ev.now_ms, asi_pkg::FAIL_NONE);
                        else if (ev.sensor_init_fault)
                            enter_mode(asi_pkg::ST_ERROR, ev.now_ms, asi_pkg::FAIL_DISARM_SENSOR);
                        else if (ev.motor_is_armed)
                            cmd_w = asi_pkg::CMD_DISARM;
                    end
                    asi_pkg::ST_PREARM: begin
                        if (disarm_q) begin
                            enter_mode(asi_pkg::ST_DISARMED, ev.now_ms, asi_pkg::FAIL_NONE);
                        end else if (dwell > {16'd0, prearm_limit}) begin
                            enter_mode(asi_pkg::ST_DISARMED, ev.now_ms, asi_pkg::FAIL_NONE);
                        end else begin
                            if (!ev.motor_ready) begin
                                code = asi_pkg::FAIL_MOTOR_NREADY;
                            end else begin
                                code = estimator_health(ev);
                                if (code == asi_pkg::FAIL_NONE) begin
                                    if (ev.sensor_init_fault)
                                        code = asi_pkg::FAIL_SENSOR;
                                    else if (ev.motor_is_armed)
                                        code = asi_pkg::FAIL_MOTOR_ARMED;
                                end
                            end
                            if (code == asi_pkg::FAIL_NONE) begin
                                enter_mode(asi_pkg::ST_ARMED, ev.now_ms, asi_pkg::FAIL_NONE);
                            end else begin
                                fail_q = code;
                                enter_mode(asi_pkg::ST_DISARMED, ev.now_ms, asi_pkg::FAIL_NONE);
                            end
                        end
                    end
                    asi_pkg::ST_ARMED: begin
                        code = estimator_health(ev);
                        if (disarm_q)
                            enter_mode(asi_pkg::ST_DISARMED, ev.now_ms, asi_pkg::FAIL_NONE);
                        else if (code != asi_pkg::FAIL_NONE)
                            enter_mode(asi_pkg::ST_FAILSAFE, ev.now_ms, code);
                        else if (ev.sensor_init_fault)
                            enter_mode(asi_pkg::ST_FAILSAFE, ev.now_ms, asi_pkg::FAIL_SENSOR);
                        else if (!ev.motor_is_armed)
                            enter_mode(asi_pkg::ST_FAILSAFE, ev.now_ms, asi_pkg::FAIL_MOTOR_DROP);
                    end
                    asi_pkg::ST_FAILSAFE: begin
                        if (ev.motor_is_armed) cmd_w = asi_pkg::CMD_ESTOP;
                        if (disarm_q)
                            enter_mode(asi_pkg::ST_DISARMED, ev.now_ms, asi_pkg::FAIL_NONE);
                        else if (ev.sensor_init_fault)
                            enter_mode(asi_pkg::ST_ERROR, ev.now_ms, asi_pkg::FAIL_FS_SENSOR);
                    end
                    asi_pkg::ST_ERROR: begin
                        if (ev.motor_is_armed) cmd_w = asi_pkg::CMD_ESTOP;
                    end
                    default: begin
                        enter_mode(asi_pkg::ST_ERROR, ev.now_ms, asi_pkg::FAIL_BAD_STATE);
                    end
                endcase
                disarm_q = 1'b0;
            end
            asi_pkg::OP_ARM: begin
                if (mode_q == asi_pkg::ST_DISARMED) arm_q = 1'b1;
                else r.accepted = 1'b0;
            end
            asi_pkg::OP_DISARM: begin
                if (mode_q == asi_pkg::ST_ERROR) r.accepted = 1'b0;
                else disarm_q = 1'b1;
            end
            default: begin
                enter_mode(asi_pkg::ST_FAILSAFE, ev.now_ms, asi_pkg::FAIL_ESTOP);
            end
        endcase
        r.safety_state  = mode_q;
        r.motor_command = cmd_w;
        r.rate_reset    = pid_w;
        r.failure_code  = fail_q;
        r.entry_time_ms = entry_q;
        r.can_arm       = (mode_q == asi_pkg::ST_DISARMED);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        asi_pkg::t_item   ev;
        asi_pkg::t_result want;
        if (!i_rst_n) begin
            mode_q       = asi_pkg::ST_BOOT;
            entry_q      = '0;
            arm_q        = 1'b0;
            disarm_q     = 1'b0;
            fail_q       = asi_pkg::FAIL_NONE;
            prearm_limit = asi_pkg::PREARM_TIMEOUT_RST;
            stale_limit  = asi_pkg::STALE_TIMEOUT_RST;
            expected_status_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == asi_pkg::CFG_PREARM) prearm_limit = i_cfg_wdata;
                else stale_limit = i_cfg_wdata;
            end
            if (i_in_valid && o_in_ready) begin
                ev.opcode            = asi_pkg::t_op'(i_opcode);
                ev.now_ms            = i_now_ms;
                ev.estimator_ready   = i_estimator_ready;
                ev.estimator_time_ms = i_estimator_time_ms;
                ev.sensor_init_fault = i_sensor_init_fault;
                ev.motor_ready       = i_motor_ready;
                ev.motor_is_armed    = i_motor_is_armed;
                expected_status_q.push_back(interlock_step(ev));
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_status_q.size() == 0) begin
                    $error("result transfer with no event outstanding");
                    mismatches++;
                end else begin
                    want = expected_status_q.pop_front();
                    check_field("safety_state", 32'(want.safety_state), 32'(o_safety_state));
                    check_field("accepted", 32'(want.accepted), 32'(o_accepted));
                    check_field("motor_command", 32'(want.motor_command),
                                32'(o_motor_command));
                    check_field("rate_reset", 32'(want.rate_reset), 32'(o_rate_reset));
                    check_field("failure_code", 32'(want.failure_code), 32'(o_failure_code));
                    check_field("entry_time_ms", want.entry_time_ms, o_entry_time_ms);
                    check_field("can_arm", 32'(want.can_arm), 32'(o_can_arm));
                    results_checked++;
                    mode_visits[want.safety_state]++;
                end
            end
        end
    end

    // receiver: ready runs and stalls of random length
    always @(posedge i_clk) begin
        if (rx_hold == 0) begin
            if (!rx_stalls || !i_out_ready) begin
                i_out_ready <= 1'b1;
                rx_hold = rx_stalls ? $urandom_range(0, 10) : 0;
            end else begin
                i_out_ready <= 1'b0;
                rx_hold = $urandom_range(0, 5);
            end
        end else begin
            rx_hold--;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic asi_pkg::t_item make_event(asi_pkg::t_op op, logic [31:0] now,
                                                  logic est_ok, logic [31:0] est_ms,
                                                  logic sensor_bad, logic motor_ok,
                                                  logic motor_on);
        asi_pkg::t_item ev;
        ev.opcode            = op;
        ev.now_ms            = now;
        ev.estimator_ready   = est_ok;
        ev.estimator_time_ms = est_ms;
        ev.sensor_init_fault = sensor_bad;
        ev.motor_ready       = motor_ok;
        ev.motor_is_armed    = motor_on;
        return ev;
    endfunction

    // requests ignore the health fields, so they carry random ones
    function automatic asi_pkg::t_item request(asi_pkg::t_op op);
        return make_event(op, $urandom(), 1'($urandom_range(0, 1)), $urandom(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
    endfunction

    function automatic asi_pkg::t_item status_tick(t_upset u, logic motor_on,
                                                   logic [31:0] step);
        logic [31:0] age;
        t_now = t_now + step;
        if (u == UPSET_EST_STALE) age = stale_limit + 32'd1 + $urandom_range(0, 1000);
        else age = $urandom_range(0, stale_limit);
        return make_event(asi_pkg::OP_TICK, t_now, u != UPSET_EST_INIT, t_now - age,
                          u == UPSET_SENSOR, u != UPSET_MOTOR_NREADY, motor_on);
    endfunction

    task automatic send_event(input asi_pkg::t_item ev);
        int gap;
        if (burst_left == 0) begin
            if (steady_tx) gap = 0;
            else if ($urandom_range(0, 15) == 0) gap = $urandom_range(8, 20);
            else gap = $urandom_range(0, 4);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid          <= 1'b1;
        i_opcode            <= ev.opcode;
        i_now_ms            <= ev.now_ms;
        i_estimator_ready   <= ev.estimator_ready;
        i_estimator_time_ms <= ev.estimator_time_ms;
        i_sensor_init_fault <= ev.sensor_init_fault;
        i_motor_ready       <= ev.motor_ready;
        i_motor_is_armed    <= ev.motor_is_armed;
        do @(posedge i_clk); while (!o_in_ready);
        events_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one pass from disarmed through pre-arm, armed flight and a way out
    task automatic fly_once();
        t_upset      upset;
        logic [31:0] step;
        if ($urandom_range(0, 3) == 0) send_event(request(asi_pkg::OP_ESTOP));
        send_event(request(asi_pkg::OP_DISARM));
        send_event(status_tick(UPSET_NONE, 1'b0, $urandom_range(0, 40)));
        send_event(request(asi_pkg::OP_ARM));
        if ($urandom_range(0, 7) == 0) send_event(request(asi_pkg::OP_DISARM));
        send_event(status_tick(UPSET_NONE, 1'b0, $urandom_range(0, 40)));
        if ($urandom_range(0, 4) == 0) step = prearm_limit + $urandom_range(0, 1);
        else step = $urandom_range(0, 40);
        upset = ($urandom_range(0, 9) < 7) ? UPSET_NONE : t_upset'($urandom_range(1, 4));
        send_event(status_tick(upset, $urandom_range(0, 9) == 0, step));
        repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 19))
                0: send_event(request(asi_pkg::OP_ARM));
                1: send_event(status_tick(t_upset'($urandom_range(1, 4)), 1'b1,
                                          $urandom_range(0, 40)));
                2: send_event(status_tick(UPSET_NONE, 1'b0, $urandom_range(0, 40)));
                default: send_event(status_tick(UPSET_NONE, 1'b1, $urandom_range(0, 40)));
            endcase
        end
        case ($urandom_range(0, 3))
            0: begin
                send_event(request(asi_pkg::OP_DISARM));
                send_event(status_tick(UPSET_NONE, 1'b0, $urandom_range(0, 40)));
            end
            1: send_event(request(asi_pkg::OP_ESTOP));
            default: begin
                repeat ($urandom_range(1, 4))
                    send_event(status_tick(($urandom_range(0, 3) == 0) ? UPSET_SENSOR
                                                                       : UPSET_NONE,
                                           1'($urandom_range(0, 1)),
                                           $urandom_range(0, 40)));
            end
        endcase
    endtask

    task automatic run_phase(input logic [15:0] prearm, input logic [15:0] stale,
                             input bit steady, input bit stalls);
        int stop_at;
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= asi_pkg::CFG_PREARM;
        i_cfg_wdata <= prearm;
        @(posedge i_clk);
        i_cfg_addr  <= asi_pkg::CFG_STALE;
        i_cfg_wdata <= stale;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        steady_tx = steady;
        rx_stalls = stalls;
        if ($urandom_range(0, 2) == 0) t_now = 32'hFFFF_FFFF - $urandom_range(0, 4000);
        else t_now = $urandom();
        stop_at = events_sent + EVENTS_PER_PHASE;
        while (events_sent < stop_at) begin
            if ($urandom_range(0, 3) == 0)
                send_event(make_event(asi_pkg::t_op'($urandom_range(0, 3)),
                                      $urandom_range(0, 1) ? $urandom() : t_now,
                                      1'($urandom_range(0, 1)),
                                      $urandom_range(0, 1) ? $urandom()
                                                           : t_now - $urandom_range(0, 300),
                                      $urandom_range(0, 3) == 0,
                                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            else
                fly_once();
        end
    endtask

    // boot with a sensor fault, then recover through failsafe
    task automatic test_error_recovery();
        send_event(make_event(asi_pkg::OP_TICK, 32'd0, 1'b0, 32'd0, 1'b1, 1'b0, 1'b0));
        send_event(make_event(asi_pkg::OP_DISARM, 32'd1, 1'b1, 32'd1, 1'b0, 1'b1, 1'b0));
        send_event(make_event(asi_pkg::OP_ARM, 32'd2, 1'b1, 32'd2, 1'b0, 1'b1, 1'b0));
        send_event(make_event(asi_pkg::OP_TICK, 32'd10, 1'b1, 32'd10, 1'b0, 1'b1, 1'b1));
        send_event(make_event(asi_pkg::OP_ESTOP, 32'd20, 1'b1, 32'd20, 1'b0, 1'b1, 1'b1));
        send_event(make_event(asi_pkg::OP_TICK, 32'd30, 1'b1, 32'd30, 1'b0, 1'b1, 1'b1));
        send_event(make_event(asi_pkg::OP_DISARM, 32'd35, 1'b1, 32'd35, 1'b0, 1'b1, 1'b0));
        send_event(make_event(asi_pkg::OP_TICK, 32'd40, 1'b1, 32'd40, 1'b0, 1'b1, 1'b0));
        send_event(make_event(asi_pkg::OP_TICK, 32'd50, 1'b1, 32'd50, 1'b0, 1'b1, 1'b1));
    endtask

    task automatic test_prearm_rejections();
        send_event(make_event(asi_pkg::OP_ARM, 32'd60, 1'b1, 32'd60, 1'b0, 1'b1, 1'b0));
        send_event(make_event(asi_pkg::OP_TICK, 32'd100, 1'b1, 32'd100, 1'b0, 1'b1, 1'b0));
        send_event(make_event(asi_pkg::OP_TICK, 32'd110, 1'b1, 32'd110, 1'b0, 1'b0, 1'b0));
        // stale estimator across the time wrap
        send_event(make_event(asi_pkg::OP_ARM, 32'd120, 1'b1, 32'd120, 1'b0, 1'b1, 1'b0));
        send_event(make_event(asi_pkg::OP_TICK, 32'hFFFF_FFF0, 1'b1, 32'hFFFF_FFF0,
                              1'b0, 1'b1, 1'b0));
        send_event(make_event(asi_pkg::OP_TICK, 32'd5, 1'b1, 32'hFFFF_FF37,
                              1'b0, 1'b1, 1'b0));
    endtask

    // estimator age exactly at the limit, then motor output drops
    task automatic test_armed_wraparound();
        send_event(make_event(asi_pkg::OP_ARM, 32'd6, 1'b1, 32'd6, 1'b0, 1'b1, 1'b0));
        send_event(make_event(asi_pkg::OP_TICK, 32'hFFFF_FF00, 1'b1, 32'hFFFF_FF00,
                              1'b0, 1'b1, 1'b0));
        send_event(make_event(asi_pkg::OP_TICK, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FF37,
                              1'b0, 1'b1, 1'b0));
        send_event(make_event(asi_pkg::OP_ARM, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                              1'b0, 1'b1, 1'b1));
        send_event(make_event(asi_pkg::OP_TICK, 32'd0, 1'b1, 32'd0, 1'b0, 1'b1, 1'b0));
        send_event(make_event(asi_pkg::OP_DISARM, 32'd2, 1'b1, 32'd2, 1'b0, 1'b1, 1'b0));
        send_event(make_event(asi_pkg::OP_TICK, 32'd4, 1'b1, 32'd4, 1'b0, 1'b1, 1'b0));
    endtask

    task automatic test_random_flights();
        run_phase(16'd0, 16'd0, 1'b0, 1'b1);
        run_phase(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b0, 1'b1);
        run_phase(16'd3, 16'd20, 1'b0, 1'b1);
        run_phase(16'($urandom_range(0, 100)), 16'($urandom_range(0, 300)), 1'b1, 1'b1);
        run_phase(asi_pkg::PREARM_TIMEOUT_RST, asi_pkg::STALE_TIMEOUT_RST, 1'b0, 1'b0);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_error_recovery();
        test_prearm_rejections();
        test_armed_wraparound();
        directed_events = events_sent;
        test_random_flights();
        settle();
        $display("checked %0d interlock results from %0d events (%0d directed), %s",
                 results_checked, events_sent, directed_events, "6 limit settings");
        $display("results by state: boot %0d, disarmed %0d, pre-arm %0d, armed %0d,",
                 mode_visits[0], mode_visits[1], mode_visits[2], mode_visits[3]);
        $display("  failsafe %0d, error %0d", mode_visits[4], mode_visits[5]);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
